### rtl/bsu_pkg.sv
// bsu_pkg: shared types, register indexes, reset values and the luma function
// of the background subtract block. No dependencies.
package bsu_pkg;

  localparam int INDEX_W = 18;
  localparam int PIX_W   = 8;
  localparam int ALPHA_W = 9;
  localparam int WORD_W  = 3 * PIX_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Request actions
  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_SUBTRACT = 1'b1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTIVE_UPDATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE       = 3'd4;

  localparam logic [PIX_W-1:0]   RST_DIFF_THRESHOLD = 8'd30;
  localparam logic [ALPHA_W-1:0] RST_ALPHA_Q8       = 9'd13;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE          = 9'd256;
  localparam logic [PIX_W-1:0]   RST_GHOST_LIMIT    = 8'd50;
  localparam logic [PIX_W-1:0]   PIX_MAX            = 8'd255;

  // BT.601 weights, Q0.14
  localparam logic [13:0] LUMA_WB = 14'd1868;
  localparam logic [13:0] LUMA_WG = 14'd9617;
  localparam logic [13:0] LUMA_WR = 14'd4899;
  localparam logic [21:0] LUMA_RND = 22'd8192;

  typedef struct packed {
    logic [PIX_W-1:0]   diff_threshold;
    logic [ALPHA_W-1:0] alpha;          // already clamped to 256
    logic               selective;
    logic [PIX_W-1:0]   ghost_limit;
    logic               color_mode;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             used;
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
  } lane_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] bkg;
    logic [PIX_W-1:0] cnt;
    logic [PIX_W-1:0] diff;
    logic             mask;
  } lane_out_t;

  function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] g,
                                            input logic [PIX_W-1:0] r);
    logic [21:0] acc;
    acc = 22'(LUMA_WB * b) + 22'(LUMA_WG * g) + 22'(LUMA_WR * r) + LUMA_RND;
    return acc[21:14];
  endfunction

endpackage

### rtl/bsu_if.sv
// bsu_if: valid/ready channels of the background subtract block, pixel
// requests in and results out. Uses bsu_pkg widths.
interface bsu_pixel_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [bsu_pkg::INDEX_W-1:0]     pixel_index;
  logic [bsu_pkg::PIX_W-1:0]       blue_in;
  logic [bsu_pkg::PIX_W-1:0]       green_in;
  logic [bsu_pkg::PIX_W-1:0]       red_in;

  modport source (output valid, action, pixel_index, blue_in, green_in, red_in,
                  input ready);
  modport sink (input valid, action, pixel_index, blue_in, green_in, red_in,
                output ready);
endinterface

interface bsu_result_if;
  logic                            valid;
  logic                            ready;
  logic [bsu_pkg::INDEX_W-1:0]     index_out;
  logic                            mask_ch0;
  logic                            mask_ch1;
  logic                            mask_ch2;
  logic [bsu_pkg::PIX_W-1:0]       diff_ch0;
  logic [bsu_pkg::PIX_W-1:0]       diff_ch1;
  logic [bsu_pkg::PIX_W-1:0]       diff_ch2;

  modport source (output valid, index_out, mask_ch0, mask_ch1, mask_ch2,
                  diff_ch0, diff_ch1, diff_ch2, input ready);
  modport sink (input valid, index_out, mask_ch0, mask_ch1, mask_ch2,
                diff_ch0, diff_ch1, diff_ch2, output ready);
endinterface

### rtl/bsu_ram.sv
// bsu_ram: single-clock simple dual-port RAM, registered read, read-first
// on a same-address write. No dependencies.
module bsu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bsu_lane.sv
// bsu_lane: one color channel. Compare/count/ghost on the read side, then a
// register, then the running-average multiply. Uses bsu_pkg.
module bsu_lane (
  input  logic               clk,
  input  logic               adv,
  input  bsu_pkg::cfg_t      cfg,
  input  bsu_pkg::lane_in_t  lin,
  output bsu_pkg::lane_out_t lout
);

  logic [7:0] d;
  logic       fg;
  logic [7:0] c_inc;
  logic [7:0] c_new;
  logic [7:0] b_base;

  // registered half
  logic       load;
  logic       used;
  logic       sel;
  logic       fg_q;
  logic [7:0] p_q;
  logic [7:0] b_q;
  logic [7:0] c_q;
  logic [7:0] d_q;

  logic signed [9:0]  delta;
  logic signed [18:0] prod;
  logic signed [18:0] acc;
  logic [7:0]         avg;

  always_comb begin
    d      = (lin.p > lin.b) ? (lin.p - lin.b) : (lin.b - lin.p);
    fg     = d > cfg.diff_threshold;
    c_inc  = fg ? ((lin.c == bsu_pkg::PIX_MAX) ? bsu_pkg::PIX_MAX : lin.c + 8'd1) : 8'd0;
    c_new  = lin.c;
    b_base = lin.b;
    if (lin.load) begin
      c_new = 8'd0;
    end else if (lin.used && cfg.selective) begin
      c_new = c_inc;
      if (c_inc > cfg.ghost_limit) begin
        b_base = lin.p;   // ghost: take the pixel as background
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      load <= lin.load;
      used <= lin.used;
      sel  <= cfg.selective;
      fg_q <= fg;
      p_q  <= lin.p;
      b_q  <= b_base;
      c_q  <= c_new;
      d_q  <= d;
    end
  end

  // avg = (256*b + a*(p-b) + 128) >> 8, never negative, never above 255
  always_comb begin
    delta = $signed({2'b00, p_q}) - $signed({2'b00, b_q});
    prod  = 19'($signed({1'b0, cfg.alpha}) * delta);
    acc   = $signed({3'b000, b_q, 8'h80}) + prod;
    avg   = acc[15:8];
  end

  always_comb begin
    lout.bkg  = b_q;
    lout.cnt  = c_q;
    lout.diff = 8'd0;
    lout.mask = 1'b0;
    if (load) begin
      lout.bkg = p_q;
    end else if (used) begin
      lout.diff = d_q;
      lout.mask = fg_q;
      lout.bkg  = (sel && fg_q) ? b_q : avg;
    end
  end

endmodule

### rtl/background_subtract_update.sv
// background_subtract_update: top level. Pipeline control, config registers,
// background and counter RAMs with forwarding. Uses bsu_pkg, bsu_if, bsu_ram, bsu_lane.

// Running-average background subtraction, one pixel request per clock. Each
// request is a load (store the pixel, or its BT.601 luma in gray mode, as the
// background and clear the foreground counters; no result) or a subtract
// (|pixel - background| per channel, mask where the difference exceeds
// diff_threshold, then update the background by a rounded running average with
// alpha in 1/256; in selective mode only background channels average, and a
// foreground counter above ghost_limit replaces the background by the pixel).
// Requests with pixel_index >= FRAME_PIXELS are taken and dropped. Throughput
// is one request per cycle while the result side takes results: the limit is
// the single read-modify-write of one entry per cycle on the background and
// counter RAMs, with same-pixel requests in flight covered by forwarding. A
// request moves through stages 1, 2 and 3 and the output register. The stores
// hold no defined value until a pixel is loaded; there is no clearing pass.
module background_subtract_update #(
  parameter int FRAME_PIXELS = 262144
) (
  input  logic                               clk,
  input  logic                               rst,
  bsu_pixel_if.sink                          pixel,
  bsu_result_if.source                       result,
  input  logic                               cfg_write,
  input  logic [bsu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int IW = bsu_pkg::INDEX_W;
  localparam int WW = bsu_pkg::WORD_W;

  // ---------------------------------------------------------------- config
  bsu_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold <= bsu_pkg::RST_DIFF_THRESHOLD;
      cfg.alpha          <= bsu_pkg::RST_ALPHA_Q8;
      cfg.selective      <= 1'b0;
      cfg.ghost_limit    <= bsu_pkg::RST_GHOST_LIMIT;
      cfg.color_mode     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bsu_pkg::REG_DIFF_THRESHOLD: cfg.diff_threshold <= cfg_data[7:0];
        // alpha above one saturates; clamp once here
        bsu_pkg::REG_ALPHA_Q8: cfg.alpha <= (cfg_data > bsu_pkg::ALPHA_ONE) ?
                                            bsu_pkg::ALPHA_ONE : cfg_data;
        bsu_pkg::REG_SELECTIVE_UPDATE: cfg.selective <= cfg_data[0];
        bsu_pkg::REG_GHOST_LIMIT: cfg.ghost_limit <= cfg_data[7:0];
        bsu_pkg::REG_COLOR_MODE: cfg.color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  // All stages move together; a bubble moves like an item.
  logic adv;
  logic in_fire;
  logic in_range;

  assign adv         = !result.valid || result.ready;
  assign pixel.ready = adv;
  assign in_fire     = pixel.valid && adv;
  assign in_range    = 32'(pixel.pixel_index) < 32'(FRAME_PIXELS);

  // ---------------------------------------------------------------- stage 1
  // holds the raw request; luma computed here
  logic          s1_valid;
  logic          s1_load;
  logic [IW-1:0] s1_idx;
  logic [7:0]    s1_b;
  logic [7:0]    s1_g;
  logic [7:0]    s1_r;
  logic [IW+AW-1:0] s1_idx_ext;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_px [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_fire && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_load <= (pixel.action == bsu_pkg::ACT_LOAD);
      s1_idx  <= pixel.pixel_index;
      s1_b    <= pixel.blue_in;
      s1_g    <= pixel.green_in;
      s1_r    <= pixel.red_in;
    end
  end

  assign s1_idx_ext = {{AW{1'b0}}, s1_idx};
  assign s1_addr    = s1_idx_ext[AW-1:0];

  always_comb begin
    if (cfg.color_mode) begin
      s1_px[0] = s1_b;
      s1_px[1] = s1_g;
      s1_px[2] = s1_r;
    end else begin
      s1_px[0] = bsu_pkg::luma(s1_b, s1_g, s1_r);
      s1_px[1] = 8'd0;
      s1_px[2] = 8'd0;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // RAM data arrives; forward the two youngest writes over it
  logic          s2_valid;
  logic          s2_load;
  logic          s2_color;
  logic [IW-1:0] s2_idx;
  logic [AW-1:0] s2_addr;
  logic [7:0]    s2_px [3];

  logic [WW-1:0] bkg_rd;
  logic [WW-1:0] cnt_rd;
  logic [WW-1:0] bkg_fwd;
  logic [WW-1:0] cnt_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_load  <= s1_load;
      s2_color <= cfg.color_mode;
      s2_idx   <= s1_idx;
      s2_addr  <= s1_addr;
      s2_px    <= s1_px;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic          s3_valid;
  logic          s3_load;
  logic [IW-1:0] s3_idx;
  logic [AW-1:0] s3_addr;
  logic [WW-1:0] bkg_wr;
  logic [WW-1:0] cnt_wr;
  logic          wr_en;

  // last write made to the RAMs: the read of stage 2 may have raced it
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  logic [WW-1:0] wb_bkg;
  logic [WW-1:0] wb_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_load <= s2_load;
      s3_idx  <= s2_idx;
      s3_addr <= s2_addr;
    end
  end

  assign wr_en = adv && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr <= s3_addr;
      wb_bkg  <= bkg_wr;
      wb_cnt  <= cnt_wr;
    end
  end

  // youngest first: stage 3 has not written yet, then the write just done
  always_comb begin
    if (s3_valid && s3_addr == s2_addr) begin
      bkg_fwd = bkg_wr;
      cnt_fwd = cnt_wr;
    end else if (wb_valid && wb_addr == s2_addr) begin
      bkg_fwd = wb_bkg;
      cnt_fwd = wb_cnt;
    end else begin
      bkg_fwd = bkg_rd;
      cnt_fwd = cnt_rd;
    end
  end

  // ---------------------------------------------------------------- stores
  bsu_ram #(.WIDTH(WW), .DEPTH(FRAME_PIXELS), .AW(AW)) u_bkg_ram (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (s1_addr),
    .rd_data (bkg_rd),
    .wr_en   (wr_en),
    .wr_addr (s3_addr),
    .wr_data (bkg_wr)
  );

  bsu_ram #(.WIDTH(WW), .DEPTH(FRAME_PIXELS), .AW(AW)) u_cnt_ram (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (s1_addr),
    .rd_data (cnt_rd),
    .wr_en   (wr_en),
    .wr_addr (s3_addr),
    .wr_data (cnt_wr)
  );

  // ---------------------------------------------------------------- lanes
  // lane 0 is blue or luma; lanes 1 and 2 are idle in gray mode
  bsu_pkg::lane_in_t  lin  [3];
  bsu_pkg::lane_out_t lout [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    always_comb begin
      lin[ch].load = s2_load;
      lin[ch].used = s2_color || (ch == 0);
      lin[ch].p    = s2_px[ch];
      lin[ch].b    = bkg_fwd[8*ch +: 8];
      lin[ch].c    = cnt_fwd[8*ch +: 8];
    end

    bsu_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .cfg  (cfg),
      .lin  (lin[ch]),
      .lout (lout[ch])
    );

    assign bkg_wr[8*ch +: 8] = lout[ch].bkg;
    assign cnt_wr[8*ch +: 8] = lout[ch].cnt;
  end

  // ---------------------------------------------------------------- output
  logic          out_valid;
  logic [IW-1:0] out_idx;
  logic [2:0]    out_mask;
  logic [7:0]    out_diff [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid && !s3_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx     <= s3_idx;
      out_mask    <= {lout[2].mask, lout[1].mask, lout[0].mask};
      out_diff[0] <= lout[0].diff;
      out_diff[1] <= lout[1].diff;
      out_diff[2] <= lout[2].diff;
    end
  end

  assign result.valid     = out_valid;
  assign result.index_out = out_idx;
  assign result.mask_ch0  = out_mask[0];
  assign result.mask_ch1  = out_mask[1];
  assign result.mask_ch2  = out_mask[2];
  assign result.diff_ch0  = out_diff[0];
  assign result.diff_ch1  = out_diff[1];
  assign result.diff_ch2  = out_diff[2];

`ifndef SYNTHESIS
  // a subtract leaving stage 3 always shows up as a result
  a_sub_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && !s3_load) |=> result.valid)
    else $error("subtract request lost before output");

  // a new result only ever comes from a subtract in stage 3
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s3_valid && !s3_load))
    else $error("result without a subtract request");

  // out-of-frame requests never enter the pipeline
  a_in_frame: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (32'(s1_idx) < 32'(FRAME_PIXELS)))
    else $error("out-of-frame index in pipeline");
`endif

endmodule
